// File: src/timed_task_scheduler_assert.svh
// Assertion macros for the timed task scheduler.
// Both macros sample on clk_i and are disabled while rst_ni is low.
`ifndef TIMED_TASK_SCHEDULER_ASSERT_SVH
`define TIMED_TASK_SCHEDULER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define TTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define TTS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`else
`define TTS_ASSERT(lbl, prop, msg)
`define TTS_ASSERT_IMP(lbl, ante, cons, msg)
`endif
`endif

// File: src/tts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tts_pkg;

  localparam int unsigned NumSlotsDef = 16;

  localparam logic [2:0] OP_ADD    = 3'd0;
  localparam logic [2:0] OP_REMOVE = 3'd1;
  localparam logic [2:0] OP_TICK   = 3'd2;
  localparam logic [2:0] OP_PAUSE  = 3'd3;
  localparam logic [2:0] OP_RESUME = 3'd4;

  localparam logic [1:0] CFG_OVERRUN_LIMIT  = 2'd0;
  localparam logic [1:0] CFG_PREPLAY_WINDOW = 2'd1;
  localparam logic [1:0] CFG_NO_DELAY_MODE  = 2'd2;

  localparam logic [31:0] OverrunLimitRst  = 32'd300000;
  localparam logic [15:0] PreplayWindowRst = 16'd100;

  localparam int unsigned InTdataW  = 176;
  localparam int unsigned OutTdataW = 104;
  localparam int unsigned EntryW    = 105;  // relative, period, deadline

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic do_exec;
    logic scan_clr;
    logic rd_en;
    logic mode_resume;
    logic do_eval;
    logic rs_finish;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [2:0] op;
    logic       paused;
    logic       pause_nz;
    logic       any_valid;
  } status_t;

endpackage
`default_nettype wire

// File: src/tts_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module tts_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule
`default_nettype wire

// File: src/tts_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
`include "timed_task_scheduler_assert.svh"
module tts_ctrl #(
  parameter int unsigned NUM_SLOTS = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  input  wire tts_pkg::status_t             status_i,
  output tts_pkg::cmd_t                     cmd_o,
  output logic [$clog2(NUM_SLOTS)-1:0]      rd_idx_o
);
  import tts_pkg::*;

  localparam int unsigned SlotW = $clog2(NUM_SLOTS);
  localparam int unsigned CntW  = $clog2(NUM_SLOTS + 1);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_EXEC  = 6'b000010,
    ST_SCAN  = 6'b000100,
    ST_EVAL  = 6'b001000,
    ST_RSCAN = 6'b010000,
    ST_DONE  = 6'b100000
  } state_e;

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            out_valid_q, out_valid_d;
  logic            cnt_end;
  logic            accept;
  logic            in_scan;

  assign cnt_end  = (cnt_q == CntW'(NUM_SLOTS));
  assign accept   = in_valid_i && in_ready_o;
  assign rd_idx_o = cnt_q[SlotW-1:0];
  assign in_scan  = (state_q == ST_SCAN) || (state_q == ST_RSCAN);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.do_exec = 1'b1;
        cnt_d         = '0;
        if (status_i.op == OP_TICK && !status_i.paused && status_i.any_valid) begin
          cmd_o.scan_clr = 1'b1;
          state_d        = ST_SCAN;
        end else if (status_i.op == OP_RESUME && status_i.paused && status_i.pause_nz) begin
          state_d = ST_RSCAN;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_SCAN: begin
        cmd_o.rd_en = !cnt_end;
        if (cnt_end) begin
          state_d = ST_EVAL;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_EVAL: begin
        cmd_o.do_eval = 1'b1;
        state_d       = ST_DONE;
      end
      ST_RSCAN: begin
        cmd_o.mode_resume = 1'b1;
        cmd_o.rd_en       = !cnt_end;
        if (cnt_end) begin
          cmd_o.rs_finish = 1'b1;
          state_d         = ST_DONE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `TTS_ASSERT(a_accept_exec, accept |=> (state_q == ST_EXEC), "accept did not start execution")
  `TTS_ASSERT_IMP(a_cnt_range, in_scan, (cnt_q <= CntW'(NUM_SLOTS)), "scan counter out of range")
  `TTS_ASSERT_IMP(a_eval_after_scan, (state_q == ST_EVAL), ($past(state_q) == ST_SCAN), "eval w/o scan")
endmodule
`default_nettype wire

// File: src/tts_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module tts_datapath #(
  parameter int unsigned NUM_SLOTS = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [1:0]                     cfg_idx_i,
  input  wire logic [31:0]                    cfg_data_i,
  input  wire logic [2:0]                     op_i,
  input  wire logic [tts_pkg::InTdataW-1:0]   in_data_i,
  input  wire tts_pkg::cmd_t                  cmd_i,
  input  wire logic [$clog2(NUM_SLOTS)-1:0]   rd_idx_i,
  output tts_pkg::status_t                    status_o,
  output logic [tts_pkg::OutTdataW-1:0]       out_data_o
);
  import tts_pkg::*;

  localparam int unsigned SlotW = $clog2(NUM_SLOTS);

  // Configuration
  logic [31:0] ovr_lim_q;
  logic [15:0] win_q;
  logic        nodelay_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovr_lim_q <= OverrunLimitRst;
      win_q     <= PreplayWindowRst;
      nodelay_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_OVERRUN_LIMIT:  ovr_lim_q <= cfg_data_i;
        CFG_PREPLAY_WINDOW: win_q     <= cfg_data_i[15:0];
        CFG_NO_DELAY_MODE:  nodelay_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Captured input
  logic [2:0]  op_q;
  logic [3:0]  slot_q;
  logic [62:0] due_q;
  logic        rel_q;
  logic [39:0] per_q;
  logic [62:0] now_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      op_q   <= op_i;
      slot_q <= in_data_i[3:0];
      due_q  <= in_data_i[66:4];
      rel_q  <= in_data_i[67];
      per_q  <= in_data_i[107:68];
      now_q  <= in_data_i[170:108];
    end
  end

  logic [63:0]      now64;
  logic             slot_ok;
  logic [SlotW-1:0] sidx;
  assign now64   = {1'b0, now_q};
  assign slot_ok = (32'(slot_q) < NUM_SLOTS);
  assign sidx    = SlotW'(slot_q);

  // Control state
  logic [NUM_SLOTS-1:0] valid_q;
  logic                 paused_q;
  logic [62:0]          ps_q;
  logic [31:0]          ovr_q;
  logic                 any_q;
  logic                 rd_pend_q;
  logic [SlotW-1:0]     ridx_q;

  // Best entry of the scan
  logic [63:0]      best_dl_q;
  logic [39:0]      best_per_q;
  logic             best_rel_q;
  logic [SlotW-1:0] best_idx_q;

  // Result
  logic        fired_q;
  logic [3:0]  fslot_q;
  logic [62:0] fdl_q;
  logic        found_q;
  logic [OutTdataW-1:0] out_q;

  // Entry store
  logic               we;
  logic [SlotW-1:0]   waddr;
  logic [EntryW-1:0]  wdata;
  logic [EntryW-1:0]  rdata;
  logic [63:0]        r_dl;
  logic [39:0]        r_per;
  logic               r_rel;

  assign r_dl  = rdata[63:0];
  assign r_per = rdata[103:64];
  assign r_rel = rdata[104];

  tts_ram #(.WIDTH(EntryW), .DEPTH(NUM_SLOTS)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(rd_idx_i),
    .rdata_o(rdata)
  );

  // Tick evaluation
  logic [63:0] lateness;
  logic        overrun;
  logic        fire;
  logic [64:0] fire_lim;
  logic [63:0] base;
  logic [64:0] reload_sum;
  logic [63:0] reload;
  assign lateness   = now64 - best_dl_q;
  assign overrun    = (best_dl_q != '0) && (now64 > best_dl_q) &&
                      (lateness > {32'd0, ovr_lim_q});
  assign fire_lim   = {1'b0, now64} + {49'd0, win_q};
  assign fire       = nodelay_q || ({1'b0, best_dl_q} <= fire_lim);
  assign base       = (best_dl_q == '0) ? now64 : best_dl_q;
  assign reload_sum = {1'b0, base} + {25'd0, best_per_q};
  assign reload     = reload_sum[64] ? '1 : reload_sum[63:0];

  // Resume shift
  logic [63:0] span;
  logic [64:0] shift_sum;
  logic [63:0] shifted;
  logic        rs_wr;
  assign span      = (now_q > ps_q) ? {1'b0, now_q - ps_q} : '0;
  assign shift_sum = {1'b0, r_dl} + {1'b0, span};
  assign shifted   = shift_sum[64] ? '1 : shift_sum[63:0];
  assign rs_wr     = cmd_i.mode_resume && rd_pend_q && valid_q[ridx_q] && r_rel;

  logic [63:0] add_sum;
  assign add_sum = rel_q ? (now64 + {1'b0, due_q}) : {1'b0, due_q};

  always_comb begin
    we    = 1'b0;
    waddr = sidx;
    wdata = {rel_q, per_q, add_sum};
    priority if (cmd_i.do_exec && op_q == OP_ADD && slot_ok) begin
      we = 1'b1;
    end else if (cmd_i.do_eval && fire && best_per_q != '0) begin
      we    = 1'b1;
      waddr = best_idx_q;
      wdata = {best_rel_q, best_per_q, reload};
    end else if (rs_wr) begin
      we    = 1'b1;
      waddr = ridx_q;
      wdata = {r_rel, r_per, shifted};
    end else begin
      we = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      paused_q  <= 1'b0;
      ps_q      <= '0;
      ovr_q     <= '0;
      any_q     <= 1'b0;
      rd_pend_q <= 1'b0;
      ridx_q    <= '0;
    end else begin
      rd_pend_q <= cmd_i.rd_en;
      ridx_q    <= rd_idx_i;
      if (cmd_i.do_exec) begin
        unique case (op_q)
          OP_ADD:    if (slot_ok) valid_q[sidx] <= 1'b1;
          OP_REMOVE: if (slot_ok) valid_q[sidx] <= 1'b0;
          OP_PAUSE: begin
            if (!paused_q) begin
              paused_q <= 1'b1;
              ps_q     <= now_q;
            end
          end
          OP_RESUME: if (paused_q && ps_q == '0) paused_q <= 1'b0;
          default: ;
        endcase
      end
      if (cmd_i.scan_clr) begin
        any_q <= 1'b0;
      end else if (rd_pend_q && !cmd_i.mode_resume && valid_q[ridx_q] &&
                   (!any_q || r_dl < best_dl_q)) begin
        any_q <= 1'b1;
      end
      if (cmd_i.do_eval) begin
        if (overrun && ovr_q != '1) ovr_q <= ovr_q + 1'b1;
        if (fire && best_per_q == '0) valid_q[best_idx_q] <= 1'b0;
      end
      if (cmd_i.rs_finish) begin
        paused_q <= 1'b0;
        ps_q     <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_pend_q && !cmd_i.mode_resume && valid_q[ridx_q] &&
        (!any_q || r_dl < best_dl_q)) begin
      best_dl_q  <= r_dl;
      best_per_q <= r_per;
      best_rel_q <= r_rel;
      best_idx_q <= ridx_q;
    end
    if (cmd_i.load_in) begin
      fired_q <= 1'b0;
      fslot_q <= '0;
      fdl_q   <= '0;
      found_q <= 1'b0;
    end
    if (cmd_i.do_exec && op_q == OP_REMOVE && slot_ok) begin
      found_q <= valid_q[sidx];
    end
    if (cmd_i.do_eval && fire) begin
      fired_q <= 1'b1;
      fslot_q <= 4'(best_idx_q);
      fdl_q   <= best_dl_q[63] ? '1 : best_dl_q[62:0];
    end
    if (cmd_i.out_load) begin
      out_q <= {2'b00, ~|valid_q, found_q, ovr_q, fdl_q, fslot_q, fired_q};
    end
  end

  assign status_o.op        = op_q;
  assign status_o.paused    = paused_q;
  assign status_o.pause_nz  = (ps_q != '0);
  assign status_o.any_valid = |valid_q;
  assign out_data_o         = out_q;
endmodule
`default_nettype wire

// File: src/timed_task_scheduler.sv
// Flow: every op is accepted, executed and written to the output register; a tick that is
// not paused and has a valid slot also scans the store and evaluates, a resume with shift rescans it.
// Throughput: one transaction at a time; the entry scan through the store
// reads one slot per cycle.
// Reset: rst_ni is asynchronous active low; all slots free, not paused, counters zero.
`timescale 1ns / 1ps
`default_nettype none
module timed_task_scheduler #(
  parameter int unsigned NUM_SLOTS = tts_pkg::NumSlotsDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration writes
  input  wire logic                          cfg_we_i,
  input  wire logic [1:0]                    cfg_idx_i,
  input  wire logic [31:0]                   cfg_data_i,
  // input stream
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata: slot[3:0], due_value[66:4], is_relative[67], reload_period[107:68],
  //        now_time[170:108], zero pad[175:171]
  input  wire logic [tts_pkg::InTdataW-1:0]  s_axis_tdata,
  // tuser: op[2:0]
  input  wire logic [2:0]                    s_axis_tuser,
  // result stream
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // tdata: fired[0], fired_slot[4:1], fired_deadline[67:5], overrun_total[99:68],
  //        found[100], table_empty[101], zero pad[103:102]
  output logic [tts_pkg::OutTdataW-1:0]      m_axis_tdata
);
  import tts_pkg::*;

  cmd_t                       cmd;
  status_t                    status;
  logic [$clog2(NUM_SLOTS)-1:0] rd_idx;

  // Sequence each transaction: execute, for a tick scan the store and evaluate, then hand
  // the result to the output register once it is free, and return to idle for the next input.
  tts_ctrl #(.NUM_SLOTS(NUM_SLOTS)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd),
    .rd_idx_o   (rd_idx)
  );

  // Hold the entry table, the pause state, the overrun count and the result.
  tts_datapath #(.NUM_SLOTS(NUM_SLOTS)) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .op_i      (s_axis_tuser),
    .in_data_i (s_axis_tdata),
    .cmd_i     (cmd),
    .rd_idx_i  (rd_idx),
    .status_o  (status),
    .out_data_o(m_axis_tdata)
  );
endmodule
`default_nettype wire
